// ----- rtl/ccc_pkg.sv -----
// Shared types and constants for the circle contact pipeline.
// Used by the square-root cells, the divider cells and the top level.
`default_nettype none

package ccc_pkg;

    // Radicand, root work register and divider widths.
    localparam int RAD_W      = 63;
    localparam int ROOT_W     = 64;
    localparam int LEN_W      = 32;
    localparam int NUM_W      = 62;
    localparam int QUO_W      = 30;
    localparam int SQRT_CELLS = 32;
    localparam int DIV_CELLS  = 30;
    localparam int NORM_SHIFT = 14;
    localparam int LANES      = 4;

    // Divider lane codes.
    localparam int LANE_CX = 0;
    localparam int LANE_CY = 1;
    localparam int LANE_NX = 2;
    localparam int LANE_NY = 3;

    // Item context carried alongside the square-root cells.
    typedef struct packed {
        logic               hit;
        logic               sdx;
        logic               sdy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [30:0]        rsum;
        logic [31:0]        mx;
        logic [31:0]        my;
        logic [NUM_W-1:0]   px;
        logic [NUM_W-1:0]   py;
    } t_pre;

    // Working state of the digit-by-digit square root.
    typedef struct packed {
        logic [RAD_W-1:0]  v;
        logic [ROOT_W-1:0] r;
        logic [RAD_W-1:0]  b;
    } t_root;

    // Item context carried alongside the divider cells.
    typedef struct packed {
        logic               hit;
        logic               zero;
        logic               sdx;
        logic               sdy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [30:0]        depth;
    } t_post;

    // Working state of the four restoring dividers sharing one divisor.
    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] q;
        logic [NUM_W-1:0]            dd;
    } t_quo;

endpackage

`default_nettype wire

// ----- rtl/circle_circle_contact.sv -----
// Circle-circle contact test. One transaction is accepted per clock and one result
// leaves per clock while the pipe is not stalled. The path from input to the output register is:
// three front stages (difference, products, squared-distance compare), 32 square-root
// cells that settle one root bit each, one rounding setup stage, 30 divider cells
// that settle one quotient bit each for the two contact offsets and the two normal
// components, and the output register. The pipeline keeps moving while a result
// waits in the output register until its last cell is also full.
// Depends on ccc_pkg, ccc_sqrt_cell and ccc_div_cell.
`default_nettype none

module circle_circle_contact import ccc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_first_x,
    input  wire logic [31:0] i_first_y,
    input  wire logic [29:0] i_first_radius,
    input  wire logic [31:0] i_second_x,
    input  wire logic [31:0] i_second_y,
    input  wire logic [29:0] i_second_radius,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_hit,
    output logic [31:0]      o_contact_x,
    output logic [31:0]      o_contact_y,
    output logic [15:0]      o_normal_x,
    output logic [15:0]      o_normal_y,
    output logic [30:0]      o_depth
);

    logic en;
    logic load;

    // Front stage 1: differences and magnitudes.
    logic        r_v1;
    logic [32:0] dx, dy;
    logic        r_sdx, r_sdy, r_cmiss;
    logic [31:0] r_mx, r_my;
    logic [30:0] r_rsum;
    logic [29:0] r_ra;
    logic [31:0] r_ax1, r_ay1;
    logic [31:0] n_mx, n_my;
    logic [30:0] n_rsum;

    // Front stage 2: products.
    logic        r_v2;
    logic        r_sdx2, r_sdy2, r_cmiss2;
    logic [31:0] r_mx2, r_my2, r_ax2, r_ay2;
    logic [30:0] r_rsum2;
    logic [63:0] r_sqx, r_sqy;
    logic [61:0] r_rs2, r_px, r_py;

    // Front stage 3: hit decision and root chain entry.
    logic        r_v3;
    t_pre        r_ctx3;
    t_root       r_st3;
    logic [64:0] sq;

    // Square-root chain.
    logic  sv   [SQRT_CELLS+1];
    t_pre  sctx [SQRT_CELLS+1];
    t_root sst  [SQRT_CELLS+1];

    // Rounding setup stage.
    logic             r_v4;
    t_post            r_ctx4;
    t_quo             r_st4;
    logic [LEN_W-1:0] len;
    logic [NUM_W-1:0] half;

    // Divider chain.
    logic  dv   [DIV_CELLS+1];
    t_post dctx [DIV_CELLS+1];
    t_quo  dst  [DIV_CELLS+1];

    // Result formation.
    t_post              fc;
    t_quo               fq;
    logic signed [33:0] sum_x, sum_y;
    logic [31:0]        n_cx, n_cy;
    logic [15:0]        n_nx, n_ny;

    // Output register.
    logic        r_ov;
    logic        r_hit;
    logic [31:0] r_cx, r_cy;
    logic [15:0] r_nx, r_ny;
    logic [30:0] r_depth;

    // The pipe advances unless both its last cell and the output register hold results.
    assign en      = !dv[DIV_CELLS] || !r_ov || !i_stall;
    assign load    = !r_ov || !i_stall;
    assign o_stall = !en;

    // Stage 1 logic.
    always_comb begin
        dx     = {i_second_x[31], i_second_x} - {i_first_x[31], i_first_x};
        dy     = {i_second_y[31], i_second_y} - {i_first_y[31], i_first_y};
        n_mx   = dx[32] ? 32'(-dx) : dx[31:0];
        n_my   = dy[32] ? 32'(-dy) : dy[31:0];
        n_rsum = {1'b0, i_first_radius} + {1'b0, i_second_radius};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= sv[SQRT_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sdx   <= dx[32];
            r_sdy   <= dy[32];
            r_mx    <= n_mx;
            r_my    <= n_my;
            r_rsum  <= n_rsum;
            r_ra    <= i_first_radius;
            r_ax1   <= i_first_x;
            r_ay1   <= i_first_y;
            r_cmiss <= ({1'b0, n_mx} > {2'b0, n_rsum}) || ({1'b0, n_my} > {2'b0, n_rsum});
        end
    end

    // Stage 2: squares and radius products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sdx2   <= r_sdx;
            r_sdy2   <= r_sdy;
            r_cmiss2 <= r_cmiss;
            r_mx2    <= r_mx;
            r_my2    <= r_my;
            r_ax2    <= r_ax1;
            r_ay2    <= r_ay1;
            r_rsum2  <= r_rsum;
            r_sqx    <= r_mx * r_mx;
            r_sqy    <= r_my * r_my;
            r_rs2    <= r_rsum * r_rsum;
            r_px     <= 62'(r_mx * r_ra);
            r_py     <= 62'(r_my * r_ra);
        end
    end

    // Stage 3: squared distance against squared radius sum.
    assign sq = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx3.hit  <= !r_cmiss2 && (sq <= {3'b0, r_rs2});
            r_ctx3.sdx  <= r_sdx2;
            r_ctx3.sdy  <= r_sdy2;
            r_ctx3.ax   <= r_ax2;
            r_ctx3.ay   <= r_ay2;
            r_ctx3.rsum <= r_rsum2;
            r_ctx3.mx   <= r_mx2;
            r_ctx3.my   <= r_my2;
            r_ctx3.px   <= r_px;
            r_ctx3.py   <= r_py;
            r_st3.v     <= sq[RAD_W-1:0];
            r_st3.r     <= '0;
            r_st3.b     <= {1'b1, {(RAD_W-1){1'b0}}};
        end
    end

    assign sv[0]   = r_v3;
    assign sctx[0] = r_ctx3;
    assign sst[0]  = r_st3;

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        ccc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sv[g]),
            .i_ctx   (sctx[g]),
            .i_st    (sst[g]),
            .o_valid (sv[g+1]),
            .o_ctx   (sctx[g+1]),
            .o_st    (sst[g+1])
        );
    end

    // Setup stage: rounded numerators, shifted divisor and depth.
    assign len  = sst[SQRT_CELLS].r[LEN_W-1:0];
    assign half = {{(NUM_W-LEN_W+1){1'b0}}, len[LEN_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx4.hit          <= sctx[SQRT_CELLS].hit;
            r_ctx4.zero         <= (len == '0);
            r_ctx4.sdx          <= sctx[SQRT_CELLS].sdx;
            r_ctx4.sdy          <= sctx[SQRT_CELLS].sdy;
            r_ctx4.ax           <= sctx[SQRT_CELLS].ax;
            r_ctx4.ay           <= sctx[SQRT_CELLS].ay;
            r_ctx4.depth        <= sctx[SQRT_CELLS].rsum - len[30:0];
            r_st4.rem[LANE_CX]  <= sctx[SQRT_CELLS].px + half;
            r_st4.rem[LANE_CY]  <= sctx[SQRT_CELLS].py + half;
            r_st4.rem[LANE_NX]  <= {16'b0, sctx[SQRT_CELLS].mx, {NORM_SHIFT{1'b0}}} + half;
            r_st4.rem[LANE_NY]  <= {16'b0, sctx[SQRT_CELLS].my, {NORM_SHIFT{1'b0}}} + half;
            r_st4.q             <= '0;
            r_st4.dd            <= {1'b0, len, {(QUO_W-1){1'b0}}};
        end
    end

    assign dv[0]   = r_v4;
    assign dctx[0] = r_ctx4;
    assign dst[0]  = r_st4;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        ccc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv[g]),
            .i_ctx   (dctx[g]),
            .i_st    (dst[g]),
            .o_valid (dv[g+1]),
            .o_ctx   (dctx[g+1]),
            .o_st    (dst[g+1])
        );
    end

    // Apply signs, add the offsets to the first centre and saturate.
    assign fc = dctx[DIV_CELLS];
    assign fq = dst[DIV_CELLS];

    always_comb begin
        sum_x = fc.sdx ? ({{2{fc.ax[31]}}, fc.ax} - $signed({4'b0, fq.q[LANE_CX]}))
                       : ({{2{fc.ax[31]}}, fc.ax} + $signed({4'b0, fq.q[LANE_CX]}));
        sum_y = fc.sdy ? ({{2{fc.ay[31]}}, fc.ay} - $signed({4'b0, fq.q[LANE_CY]}))
                       : ({{2{fc.ay[31]}}, fc.ay} + $signed({4'b0, fq.q[LANE_CY]}));
        if (sum_x > 34'sh0_7FFF_FFFF) begin
            n_cx = 32'h7FFF_FFFF;
        end else if (sum_x < -34'sh0_8000_0000) begin
            n_cx = 32'h8000_0000;
        end else begin
            n_cx = sum_x[31:0];
        end
        if (sum_y > 34'sh0_7FFF_FFFF) begin
            n_cy = 32'h7FFF_FFFF;
        end else if (sum_y < -34'sh0_8000_0000) begin
            n_cy = 32'h8000_0000;
        end else begin
            n_cy = sum_y[31:0];
        end
        n_nx = fc.sdx ? fq.q[LANE_NX][15:0] : 16'(-fq.q[LANE_NX][15:0]);
        n_ny = fc.sdy ? fq.q[LANE_NY][15:0] : 16'(-fq.q[LANE_NY][15:0]);
        if (fc.zero) begin
            n_cx = fc.ax;
            n_cy = fc.ay;
            n_nx = '0;
            n_ny = '0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= dv[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_hit   <= fc.hit;
            r_cx    <= fc.hit ? n_cx : '0;
            r_cy    <= fc.hit ? n_cy : '0;
            r_nx    <= fc.hit ? n_nx : '0;
            r_ny    <= fc.hit ? n_ny : '0;
            r_depth <= fc.hit ? fc.depth : '0;
        end
    end

    assign o_valid     = r_ov;
    assign o_hit       = r_hit;
    assign o_contact_x = r_cx;
    assign o_contact_y = r_cy;
    assign o_normal_x  = r_nx;
    assign o_normal_y  = r_ny;
    assign o_depth     = r_depth;

endmodule

`default_nettype wire

// ----- rtl/ccc_sqrt_cell.sv -----
// One root bit of the square-root chain, with its context register.
// Depends on ccc_pkg.
`default_nettype none

module ccc_sqrt_cell import ccc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_pre  i_ctx,
    input  wire t_root i_st,
    output logic       o_valid,
    output t_pre       o_ctx,
    output t_root      o_st
);

    logic              r_valid;
    t_pre              r_ctx;
    t_root             r_st;
    t_root             n_st;
    logic [ROOT_W-1:0] trial;

    // Try to subtract r + bit from the remainder and settle one root bit.
    always_comb begin
        trial = i_st.r + {1'b0, i_st.b};
        n_st.b = i_st.b >> 2;
        if ({1'b0, i_st.v} >= trial) begin
            n_st.v = i_st.v - trial[RAD_W-1:0];
            n_st.r = (i_st.r >> 1) + {1'b0, i_st.b};
        end else begin
            n_st.v = i_st.v;
            n_st.r = i_st.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= i_ctx;
            r_st  <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_st    = r_st;

endmodule

`default_nettype wire

// ----- rtl/ccc_div_cell.sv -----
// One quotient bit of four restoring dividers that share a divisor.
// Depends on ccc_pkg.
`default_nettype none

module ccc_div_cell import ccc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_post i_ctx,
    input  wire t_quo  i_st,
    output logic       o_valid,
    output t_post      o_ctx,
    output t_quo       o_st
);

    logic  r_valid;
    t_post r_ctx;
    t_quo  r_st;
    t_quo  n_st;

    // Each lane compares its remainder with the shifted divisor.
    always_comb begin
        n_st.dd = i_st.dd >> 1;
        for (int k = 0; k < LANES; k++) begin
            if (i_st.rem[k] >= i_st.dd) begin
                n_st.rem[k] = i_st.rem[k] - i_st.dd;
                n_st.q[k]   = {i_st.q[k][QUO_W-2:0], 1'b1};
            end else begin
                n_st.rem[k] = i_st.rem[k];
                n_st.q[k]   = {i_st.q[k][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= i_ctx;
            r_st  <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_st    = r_st;

endmodule

`default_nettype wire
